### sv/hel_pkg.sv
// Shared types, constants and entity lookup for the HTML escape / line normalizer.
package hel_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] LF_BYTE = 8'h0A;
	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] AMP_BYTE = 8'h26;
	localparam logic [7:0] LT_BYTE = 8'h3C;
	localparam logic [7:0] GT_BYTE = 8'h3E;
	localparam logic [7:0] QUOT_BYTE = 8'h22;

	typedef enum logic [1:0] {
		PH_START,
		PH_RUN,
		PH_BODY,
		PH_AFTER_CR
	} phase_t;

	typedef enum logic [2:0] {
		CK_NONE,
		CK_BYTE,
		CK_AMP,
		CK_LT,
		CK_GT,
		CK_QUOT
	} ch_kind_t;

	// One queued job: leading LFs, then an optional byte or entity.
	typedef struct packed {
		logic [1:0] lf_cnt;
		ch_kind_t   kind;
		logic [7:0] chr;
	} job_t;

	function automatic logic [2:0] kind_len(input ch_kind_t kind);
		logic [2:0] n;
		case (kind)
			CK_BYTE: n = 3'd1;
			CK_AMP:  n = 3'd5;
			CK_LT:   n = 3'd4;
			CK_GT:   n = 3'd4;
			CK_QUOT: n = 3'd6;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Byte j of an entity string.
	function automatic logic [7:0] ent_byte(input ch_kind_t kind, input logic [2:0] j);
		logic [7:0] b;
		b = ";";
		case (kind)
			CK_AMP: begin
				case (j)
					3'd0: b = "&";
					3'd1: b = "a";
					3'd2: b = "m";
					3'd3: b = "p";
					default: b = ";";
				endcase
			end
			CK_LT: begin
				case (j)
					3'd0: b = "&";
					3'd1: b = "l";
					3'd2: b = "t";
					default: b = ";";
				endcase
			end
			CK_GT: begin
				case (j)
					3'd0: b = "&";
					3'd1: b = "g";
					3'd2: b = "t";
					default: b = ";";
				endcase
			end
			CK_QUOT: begin
				case (j)
					3'd0: b = "&";
					3'd1: b = "q";
					3'd2: b = "u";
					3'd3: b = "o";
					3'd4: b = "t";
					default: b = ";";
				endcase
			end
			default: b = ";";
		endcase
		return b;
	endfunction

endpackage

### sv/hel_in_if.sv
// Input text channel: one byte or end-of-text marker per beat.
interface hel_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

### sv/hel_out_if.sv
// Output text channel: one converted byte per beat.
interface hel_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

### sv/html_escape_line_normalizer_top.sv
// Top level of the HTML escape and line-ending normalizer.
//
// Text bytes arrive on in_ch, one per beat, with end_of_text marking the end
// of a stream in place of a byte. Converted bytes leave on out_ch with
// last_of_run set on the final byte that an input beat caused; a beat can
// cause zero to seven output bytes. The front end classifies each beat in the
// cycle it is accepted and takes a beat every cycle while the job queue
// (QUEUE_DEPTH entries) has room. The back end emits one output byte per
// cycle while out_ch is not stalled; a job has one byte for a plain byte,
// four to six for an entity, plus one per pending LF. Plain text therefore
// streams at one beat per cycle when out_ch does not stall; entity expansion
// throttles the input once the queue fills. A beat passes the job queue and the
// output register before its first byte leaves. The user must write escape_enable
// through cfg_we/cfg_wdata only while the block is idle; the block does not check.
module html_escape_line_normalizer_top #(
	parameter int QUEUE_DEPTH = hel_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	hel_in_if.sink    in_ch,
	hel_out_if.source out_ch
);
	import hel_pkg::*;

	logic escape_enable_q;

	// front -> queue
	logic q_push;
	logic q_full;
	job_t q_job;

	// queue -> back
	logic q_pop;
	logic q_head_valid;
	job_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b0;
		end else if (cfg_we) begin
			escape_enable_q <= cfg_wdata;
		end
	end

	hel_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.escape_enable (escape_enable_q),
		.in_ch         (in_ch),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (q_job)
	);

	hel_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head)
	);

	hel_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head),
		.pop        (q_pop),
		.out_ch     (out_ch)
	);
endmodule

### sv/hel_front.sv
// Front end: accepts input beats, tracks line phase, classifies into jobs.
module hel_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             escape_enable,
	hel_in_if.sink           in_ch,
	input  logic             q_full,
	output logic             q_push,
	output hel_pkg::job_t    q_job
);
	import hel_pkg::*;

	phase_t phase_q;
	phase_t phase_d;
	logic   acc;
	logic   is_eol;

	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign is_eol = (in_ch.data_byte == LF_BYTE) || (in_ch.data_byte == CR_BYTE);

	// next state
	always_comb begin
		phase_d = phase_q;
		if (in_ch.end_of_text) begin
			phase_d = PH_START;
		end else if (is_eol) begin
			case (phase_q)
				PH_START, PH_RUN: phase_d = PH_RUN;
				PH_BODY: phase_d = (in_ch.data_byte == CR_BYTE) ? PH_AFTER_CR : PH_START;
				PH_AFTER_CR: phase_d = (in_ch.data_byte == LF_BYTE) ? PH_START : PH_RUN;
				default: phase_d = PH_START;
			endcase
		end else begin
			phase_d = PH_BODY;
		end
	end

	// job classification
	always_comb begin
		q_job.lf_cnt = 2'd0;
		q_job.kind = CK_NONE;
		q_job.chr = in_ch.data_byte;
		if (in_ch.end_of_text) begin
			case (phase_q)
				PH_RUN:  q_job.lf_cnt = 2'd2;
				PH_BODY: q_job.lf_cnt = 2'd1;
				default: q_job.lf_cnt = 2'd0;
			endcase
		end else if (is_eol) begin
			q_job.lf_cnt = (phase_q == PH_BODY) ? 2'd1 : 2'd0;
		end else begin
			q_job.lf_cnt = (phase_q == PH_RUN) ? 2'd1 : 2'd0;
			q_job.kind = CK_BYTE;
			if (escape_enable) begin
				case (in_ch.data_byte)
					AMP_BYTE:  q_job.kind = CK_AMP;
					LT_BYTE:   q_job.kind = CK_LT;
					GT_BYTE:   q_job.kind = CK_GT;
					QUOT_BYTE: q_job.kind = CK_QUOT;
					default:   q_job.kind = CK_BYTE;
				endcase
			end
		end
	end

	// beats that produce no output bytes never enter the queue
	assign q_push = acc && ((q_job.lf_cnt != 2'd0) || (q_job.kind != CK_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
		end else if (acc) begin
			phase_q <= phase_d;
		end
	end

	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_ch.end_of_text) |=> (phase_q == PH_START))
		else $error("phase not reset after end of text");

	a_text_body: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !in_ch.end_of_text && !is_eol) |=> (phase_q == PH_BODY))
		else $error("text byte did not enter body phase");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");
endmodule

### sv/hel_queue.sv
// Small job queue decoupling the front end from the byte expander.
module hel_queue #(
	parameter int DEPTH = hel_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hel_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output hel_pkg::job_t  head_job
);
	import hel_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == cnt_q[PTR_W-1:0])
		else $error("queue pointers disagree with count");
endmodule

### sv/hel_back.sv
// Back end: expands queued jobs into output bytes, one per cycle while out_ch is not stalled.
module hel_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  hel_pkg::job_t  head_job,
	output logic           pop,
	hel_out_if.source      out_ch
);
	import hel_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] total;
	logic [2:0] lf_ext;
	logic [2:0] ent_idx;
	logic       adv;
	logic       is_last;
	logic [7:0] cur_byte;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	assign lf_ext = {1'b0, head_job.lf_cnt};
	assign total = lf_ext + kind_len(head_job.kind);
	assign ent_idx = idx_q - lf_ext;
	assign is_last = (idx_q == total - 3'd1);
	assign adv = head_valid && (!out_valid_q || out_ch.ready);
	assign pop = adv && is_last;

	always_comb begin
		if (idx_q < lf_ext) begin
			cur_byte = LF_BYTE;
		end else if (head_job.kind == CK_BYTE) begin
			cur_byte = head_job.chr;
		end else begin
			cur_byte = ent_byte(head_job.kind, ent_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last_of_run = out_last_q;

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < total))
		else $error("expander index past end of job");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == 3'd0))
		else $error("expander index left mid-job with empty queue");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && out_last_q))
		else $error("job retired without a last byte");
endmodule

### test/tb_html_escape_line_normalizer_top.sv
// Testbench for the HTML escape / line normalizer: directed table plus random text, scoreboarded.
module tb_html_escape_line_normalizer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hel_pkg::*;

	// Plenty for ~225 beats at up to 7 bytes each with worst-case stalls on both sides.
	localparam int CYCLE_LIMIT = 200000;
	// Beats that produce nothing may still be in flight once the queue is empty;
	// SETTLE_CYCLES gives them a generous margin.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	// Line terminator styles for the random text generator.
	localparam int EOL_LF = 0;
	localparam int EOL_CR = 1;
	localparam int EOL_CRLF = 2;
	localparam int EOL_NONE = 3;

	typedef enum logic [1:0] {
		RK_TEXT,
		RK_END,
		RK_CFG
	} row_kind_t;

	// One directed row. For RK_CFG, bit 0 of data is the escape_enable value.
	// Where typed is set, want holds the exact output bytes for that beat.
	typedef struct {
		row_kind_t  kind;
		logic [7:0] data;
		bit         typed;
		string      want;
	} stim_row_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} text_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	hel_in_if  in_ch ();
	hel_out_if out_ch ();

	html_escape_line_normalizer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Predictor state: mirrors line phase and the escape register.
	phase_t line_state;
	logic   escape_on;

	// Output bytes still owed by the block, oldest first.
	text_beat_t pending_bytes[$];

	int  fail_count;
	int  report_count;
	int  beats_sent;
	int  cycle_count;
	bit  source_steady;
	bit  sink_steady;

	stim_row_t directed_rows[25];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost byte ends up here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Queue one beat's worth of output bytes; the final one carries last_of_run.
	task automatic post_expected(input logic [7:0] q[$]);
		foreach (q[k])
			pending_bytes.push_back('{q[k], k == q.size() - 1});
	endtask

	// Advance the line state machine by one accepted beat and, when keep is
	// set, queue the bytes it produces.
	task automatic normalize_beat(input logic [7:0] b, input logic eot, input bit keep);
		logic [7:0] emitted[$];
		string      ent;
		emitted = {};
		ent = "";
		if (eot) begin
			// A pending blank line plus the empty last line give two LFs.
			if (line_state == PH_RUN) begin
				emitted.push_back(LF_BYTE);
				emitted.push_back(LF_BYTE);
			end else if (line_state == PH_BODY) begin
				emitted.push_back(LF_BYTE);
			end
			line_state = PH_START;
		end else if (b == LF_BYTE || b == CR_BYTE) begin
			case (line_state)
				PH_START, PH_RUN: line_state = PH_RUN;
				PH_BODY: begin
					emitted.push_back(LF_BYTE);
					line_state = (b == CR_BYTE) ? PH_AFTER_CR : PH_START;
				end
				// After CR: LF completes the CRLF silently, CR opens a blank run.
				default: line_state = (b == LF_BYTE) ? PH_START : PH_RUN;
			endcase
		end else begin
			// The held-back LF of a blank run leaves ahead of the text byte.
			if (line_state == PH_RUN)
				emitted.push_back(LF_BYTE);
			if (escape_on) begin
				case (b)
					AMP_BYTE:  ent = "&amp;";
					LT_BYTE:   ent = "&lt;";
					GT_BYTE:   ent = "&gt;";
					QUOT_BYTE: ent = "&quot;";
					default:   ent = "";
				endcase
			end
			if (ent.len() == 0)
				emitted.push_back(b);
			else
				for (int k = 0; k < ent.len(); k++)
					emitted.push_back(ent[k]);
			line_state = PH_BODY;
		end
		if (keep)
			post_expected(emitted);
	endtask

	// Drive one input beat after a random gap; returns at the accepting edge.
	task automatic send_beat(input logic [7:0] b, input logic eot, input bit keep);
		int gap;
		if ($urandom_range(0, 19) == 0)
			source_steady = !source_steady;
		gap = source_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_text <= eot;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		beats_sent++;
		normalize_beat(b, eot, keep);
	endtask

	// Stop sending and let every owed byte drain, then let zero-output beats finish.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_escape(input logic v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		escape_on = v;
	endtask

	// Text bytes biased toward the escapable characters.
	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 7))
			0: return AMP_BYTE;
			1: return LT_BYTE;
			2: return GT_BYTE;
			3: return QUOT_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_eol(input int style);
		case (style)
			EOL_LF: send_beat(LF_BYTE, 1'b0, 1'b1);
			EOL_CR: send_beat(CR_BYTE, 1'b0, 1'b1);
			EOL_CRLF: begin
				send_beat(CR_BYTE, 1'b0, 1'b1);
				send_beat(LF_BYTE, 1'b0, 1'b1);
			end
			default: ;
		endcase
	endtask

	// Mostly well-formed documents: text lines with mixed terminators, blank
	// runs and end-of-text markers; about one pick in six is raw noise.
	task automatic send_text_stream(input int beats);
		int target;
		int len;
		target = beats_sent + beats;
		while (beats_sent < target) begin
			case ($urandom_range(0, 5))
				0: send_beat(text_byte(), $urandom_range(0, 7) == 0, 1'b1);
				1: repeat ($urandom_range(1, 3)) send_eol($urandom_range(EOL_LF, EOL_CRLF));
				default: begin
					len = $urandom_range(1, 8);
					repeat (len) send_beat(text_byte(), 1'b0, 1'b1);
					send_eol($urandom_range(EOL_LF, EOL_NONE));
				end
			endcase
			// End of document; the byte lane carries junk that must be ignored.
			if ($urandom_range(0, 5) == 0)
				send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	task automatic check_result(input logic [7:0] b, input logic last);
		text_beat_t want;
		if (pending_bytes.size() == 0) begin
			fail_count++;
			if (report_count < MAX_REPORTS) begin
				report_count++;
				$display("unexpected output beat: byte %02h last %0b", b, last);
			end
		end else begin
			want = pending_bytes.pop_front();
			if (want.b !== b || want.last !== last) begin
				fail_count++;
				if (report_count < MAX_REPORTS) begin
					report_count++;
					$display("output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
						want.b, want.last, b, last);
				end
			end
		end
	endtask

	// Result side: random ready stalls per beat, with steady stretches, and the
	// scoreboard check at each accepting edge.
	initial begin : result_sink
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 19) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (out_ch.valid !== 1'b1) @(posedge clk);
			check_result(out_ch.out_byte, out_ch.last_of_run);
		end
	end

	initial begin : stimulus
		logic [7:0] typed_q[$];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.end_of_text <= 1'b0;
		line_state = PH_START;
		escape_on = 1'b0;
		fail_count = 0;
		report_count = 0;
		beats_sent = 0;

		// Directed walk. Escaping is off out of reset, so specials pass through
		// first; then entities, line-ending transitions and the EOT cases.
		directed_rows = '{
			'{RK_TEXT, AMP_BYTE,  1'b1, "&"},
			'{RK_TEXT, LT_BYTE,   1'b1, "<"},
			'{RK_TEXT, QUOT_BYTE, 1'b1, "\""},
			'{RK_TEXT, GT_BYTE,   1'b1, ">"},
			'{RK_END,  LF_BYTE,   1'b1, "\n"},       // EOT in body; byte lane ignored
			'{RK_CFG,  8'h01,     1'b0, ""},
			'{RK_TEXT, AMP_BYTE,  1'b1, "&amp;"},
			'{RK_TEXT, LT_BYTE,   1'b1, "&lt;"},
			'{RK_TEXT, GT_BYTE,   1'b1, "&gt;"},
			'{RK_TEXT, QUOT_BYTE, 1'b1, "&quot;"},
			'{RK_TEXT, 8'h41,     1'b1, "A"},
			'{RK_TEXT, CR_BYTE,   1'b1, "\n"},       // line ends with CR
			'{RK_TEXT, LF_BYTE,   1'b1, ""},         // LF of CRLF swallowed
			'{RK_TEXT, LF_BYTE,   1'b1, ""},         // blank run opens
			'{RK_TEXT, CR_BYTE,   1'b1, ""},         // still in run
			'{RK_TEXT, QUOT_BYTE, 1'b1, "\n&quot;"}, // held LF plus longest entity
			'{RK_TEXT, CR_BYTE,   1'b1, "\n"},
			'{RK_TEXT, CR_BYTE,   1'b1, ""},         // CR after CR opens a run
			'{RK_END,  8'hFF,     1'b1, "\n\n"},     // EOT inside a run
			'{RK_END,  8'h00,     1'b1, ""},         // EOT at line start
			'{RK_TEXT, 8'hFF,     1'b1, "\377"},     // top byte is plain text
			'{RK_TEXT, 8'h00,     1'b0, ""},
			'{RK_TEXT, CR_BYTE,   1'b1, "\n"},
			'{RK_END,  8'h5A,     1'b1, ""},         // EOT right after CR
			'{RK_CFG,  8'h00,     1'b0, ""}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				RK_CFG: write_escape(directed_rows[i].data[0]);
				default: begin
					send_beat(directed_rows[i].data, directed_rows[i].kind == RK_END,
						!directed_rows[i].typed);
					if (directed_rows[i].typed) begin
						typed_q = {};
						for (int k = 0; k < directed_rows[i].want.len(); k++)
							typed_q.push_back(directed_rows[i].want[k]);
						post_expected(typed_q);
					end
				end
			endcase
		end

		// Random documents in four phases, escaping toggled between them. Each
		// register write first drains the block, which doubles as the full
		// sender pause.
		for (int seg = 0; seg < 4; seg++) begin
			write_escape(~seg[0]);
			send_text_stream(50);
		end

		settle();
		if (fail_count == 0 && pending_bytes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
